@@ hw/rtl/vwpm_pkg.sv @@
package vwpm_pkg;

	// Input pixel width and output value width.
	localparam int PIXEL_BITS = 16;
	localparam int OUT_W      = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register widths.
	localparam int WD_W  = 16;
	localparam int RNG_W = OUT_W + 1;

	// Pixel minus center, and the compare width against eight window widths.
	localparam int D_W   = ((PIXEL_BITS > WD_W) ? PIXEL_BITS : WD_W) + 1;
	localparam int CMP_W = (D_W > WD_W + 3) ? D_W : WD_W + 3;

	// Q30 fixed point for the exponential.
	localparam int Q_FRAC    = 30;
	localparam int Q_W       = Q_FRAC + 1;
	localparam int VQ_W      = 30;
	localparam int TERMS     = 12;
	localparam int SQUARINGS = 5;
	localparam int RCP_SH    = 32;
	localparam int RCP_W     = RCP_SH + 1;
	localparam logic [Q_W-1:0] Q30_ONE = {1'b1, {Q_FRAC{1'b0}}};

	// Final divider operands.
	localparam int PR_W  = RNG_W + Q_W + 1;
	localparam int DS_W  = Q_W + 1;
	localparam int LIN_W = D_W + RNG_W + 3;
	localparam int SIG_W = PR_W + 1;
	localparam int NUM_W = (LIN_W > SIG_W) ? LIN_W : SIG_W;
	localparam int DEN_W = DS_W + 1;

	// Transfer curve codes.
	localparam logic [1:0] MODE_LINEAR  = 2'd0;
	localparam logic [1:0] MODE_SIGMOID = 2'd2;

	// Register reset values.
	localparam logic signed [WD_W-1:0] CENTER_RST  = 16'sd40;
	localparam logic [WD_W-1:0]        WIDTH_RST   = 16'd400;
	localparam logic [OUT_W-1:0]       OUT_MIN_RST = 16'd0;
	localparam logic [OUT_W-1:0]       OUT_MAX_RST = 16'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_CENTER,
		REG_WIDTH,
		REG_OUT_MIN,
		REG_OUT_MAX
	} cfg_reg_t;

	// Per-item control that travels down the sigmoid pipeline.
	typedef struct packed {
		logic vld;
		logic neg;
		logic sat;
	} vwpm_tag_t;

	// Divider result: negative numerator, quotient too large, or 16-bit quotient.
	typedef struct packed {
		logic             vld;
		logic             neg;
		logic             sat;
		logic [OUT_W-1:0] quo;
	} vwpm_quo_t;

	// floor(2^32 / i) for the series term divisors.
	function automatic logic [RCP_W-1:0] vwpm_recip(input int unsigned i);
		logic [RCP_W-1:0] m;
		unique case (i)
			1:       m = 33'h1_0000_0000;
			2:       m = 33'h0_8000_0000;
			3:       m = 33'h0_5555_5555;
			4:       m = 33'h0_4000_0000;
			5:       m = 33'h0_3333_3333;
			6:       m = 33'h0_2AAA_AAAA;
			7:       m = 33'h0_2492_4924;
			8:       m = 33'h0_2000_0000;
			9:       m = 33'h0_1C71_C71C;
			10:      m = 33'h0_1999_9999;
			11:      m = 33'h0_1745_D174;
			12:      m = 33'h0_1555_5555;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

@@ hw/rtl/voi_window_pixel_mapper_unit.sv @@
// VOI window pixel mapper.
//
// Maps each signed pixel through a display window (center, width) onto the
// range out_min..out_max, with a linear curve (modes 0, 1, 3) or a sigmoid
// curve (mode 2). Results are clamped into the output range.
//
// Input: a pixel transfers on a clock edge with start high and busy low. Busy
// stays low, so a new pixel may be started on every clock.
// Output: done is high for one cycle with pixel_out valid. The receiver has
// no way to hold results off; every result appears exactly once, in order.
// Config: cfg_valid with cfg_ready (always high) writes cfg_data into the
// register selected by cfg_index (0 mode, 1 center, 2 width, 3 out_min,
// 4 out_max); other indexes are dropped. Write only while no pixel is in flight.
//
// Pipeline: the linear modes pass through the 16-step quotient divider, and
// sigmoid mode adds the 30-step window divider and the 36 series and 5
// squaring stages of the exponential. Throughput is one pixel per clock in
// every mode.
// Reset clears all valid bits and loads the register defaults.
module voi_window_pixel_mapper_unit (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	output logic                                         busy,
	input  logic signed [vwpm_pkg::PIXEL_BITS-1:0]       pixel_in,
	output logic                                         done,
	output logic        [vwpm_pkg::OUT_W-1:0]            pixel_out,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic        [vwpm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic        [vwpm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import vwpm_pkg::*;

	// Configuration registers.
	logic [1:0]              mode_q;
	logic signed [WD_W-1:0]  center_q;
	logic [WD_W-1:0]         width_q;
	logic [OUT_W-1:0]        omin_q;
	logic [OUT_W-1:0]        omax_q;

	logic [WD_W-1:0]         w_eff;
	logic signed [RNG_W-1:0] rng;
	logic                    sig_mode;
	logic                    accept;

	// Front stages.
	logic                    vld_s1;
	logic signed [D_W-1:0]   d_s1;
	logic [D_W-1:0]          ad;
	logic [D_W-1:0]          ad_sh;
	logic                    sat_in;
	logic signed [D_W+1:0]   two_d_w;

	logic                       vld_s2;
	logic signed [LIN_W-2:0]    lin_m_s2;
	logic [WD_W-1:0]            r0_s2;
	logic [2:0]                 low3_s2;
	logic                       neg_s2;
	logic                       sat_s2;

	// Window divider stages for v = |d| * 2^27 / w.
	vwpm_tag_t       vd_tag_s [1:VQ_W];
	logic [WD_W-1:0] vd_rem_s [1:VQ_W];
	logic [2:0]      vd_low_s [1:VQ_W];
	logic [VQ_W-1:0] vd_quo_s [1:VQ_W];

	vwpm_tag_t      exp_tag;
	logic [Q_W-1:0] exp_e;

	// Sigmoid numerator stage.
	logic [Q_W-1:0]          sig_n;
	logic                    sgp_vld_s1;
	logic signed [PR_W-1:0]  sgp_prod_s1;
	logic [DS_W-1:0]         sgp_den_s1;

	logic signed [NUM_W-1:0] lin_num;
	logic signed [NUM_W-1:0] sig_num;
	logic signed [NUM_W-1:0] div_num;
	logic [DEN_W-1:0]        div_den;
	logic                    div_vld;
	vwpm_quo_t               div_res;

	logic                    over;
	logic [OUT_W-1:0]        result;
	logic                    done_q;
	logic [OUT_W-1:0]        pixel_out_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LINEAR;
			center_q <= CENTER_RST;
			width_q  <= WIDTH_RST;
			omin_q   <= OUT_MIN_RST;
			omax_q   <= OUT_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:    mode_q   <= cfg_data[1:0];
				REG_CENTER:  center_q <= $signed(cfg_data[WD_W-1:0]);
				REG_WIDTH:   width_q  <= cfg_data[WD_W-1:0];
				REG_OUT_MIN: omin_q   <= cfg_data[OUT_W-1:0];
				REG_OUT_MAX: omax_q   <= cfg_data[OUT_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero width acts as a width of one.
	assign w_eff    = (width_q == '0) ? WD_W'(1) : width_q;
	assign rng      = $signed({1'b0, omax_q}) - $signed({1'b0, omin_q});
	assign sig_mode = mode_q == MODE_SIGMOID;

	// Stage 1: distance from the window center.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= D_W'(pixel_in) - D_W'(center_q);
	end

	// Stage 2: linear numerator product and window divider setup.
	assign ad      = d_s1[D_W-1] ? D_W'(-d_s1) : D_W'(d_s1);
	assign ad_sh   = ad >> 3;
	assign sat_in  = CMP_W'(ad) >= CMP_W'({w_eff, 3'b000});
	assign two_d_w = ((D_W+2)'(d_s1) <<< 1) + $signed((D_W+2)'(w_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lin_m_s2 <= (LIN_W-1)'(rng) * (LIN_W-1)'(two_d_w);
		r0_s2    <= ad_sh[WD_W-1:0];
		low3_s2  <= ad[2:0];
		neg_s2   <= d_s1[D_W-1];
		sat_s2   <= sat_in;
	end

	// Window divider: one quotient bit of v per stage.
	for (genvar K = 1; K <= VQ_W; K++) begin : g_vdiv
		vwpm_tag_t       tag_in;
		logic [WD_W-1:0] rem_in;
		logic [2:0]      low_in;
		logic [VQ_W-1:0] quo_in;
		logic [WD_W:0]   trial;
		logic            ge;

		if (K == 1) begin : g_first
			assign tag_in = '{vld: vld_s2 && sig_mode, neg: neg_s2, sat: sat_s2};
			assign rem_in = r0_s2;
			assign low_in = low3_s2;
			assign quo_in = '0;
		end else begin : g_chain
			assign tag_in = vd_tag_s[K-1];
			assign rem_in = vd_rem_s[K-1];
			assign low_in = vd_low_s[K-1];
			assign quo_in = vd_quo_s[K-1];
		end

		assign trial = {rem_in, low_in[2]};
		assign ge    = trial >= {1'b0, w_eff};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_tag_s[K] <= '0;
			end else begin
				vd_tag_s[K] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			vd_rem_s[K] <= ge ? WD_W'(trial - {1'b0, w_eff}) : trial[WD_W-1:0];
			vd_low_s[K] <= {low_in[1:0], 1'b0};
			vd_quo_s[K] <= {quo_in[VQ_W-2:0], ge};
		end
	end

	vwpm_exp u_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_tag  (vd_tag_s[VQ_W]),
		.v_in    (vd_quo_s[VQ_W]),
		.out_tag (exp_tag),
		.e_out   (exp_e)
	);

	// Sigmoid numerator r * n and denominator 1 + e.
	assign sig_n = exp_tag.neg ? exp_e : Q30_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sgp_vld_s1 <= 1'b0;
		end else begin
			sgp_vld_s1 <= exp_tag.vld;
		end
	end

	always_ff @(posedge clk) begin
		sgp_prod_s1 <= PR_W'(rng) * PR_W'($signed({1'b0, sig_n}));
		sgp_den_s1  <= DS_W'(Q30_ONE) + DS_W'(exp_e);
	end

	// Pick the divider operands of the active curve.
	assign lin_num = NUM_W'(lin_m_s2) + NUM_W'($signed({1'b0, w_eff}));
	assign sig_num = (NUM_W'(sgp_prod_s1) <<< 1) + NUM_W'($signed({1'b0, sgp_den_s1}));
	assign div_num = sig_mode ? sig_num : lin_num;
	assign div_den = sig_mode ? {sgp_den_s1, 1'b0} : DEN_W'({w_eff, 1'b0});
	assign div_vld = sig_mode ? sgp_vld_s1 : vld_s2;

	vwpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (div_vld),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// Clamp: below range gives out_min, beyond the span gives out_max.
	assign over   = $signed({1'b0, div_res.quo}) > rng;
	assign result = div_res.neg ? omin_q :
			(div_res.sat || over) ? omax_q : omin_q + div_res.quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_res.vld;
		end
	end

	always_ff @(posedge clk) begin
		pixel_out_q <= result;
	end

	assign done      = done_q;
	assign pixel_out = pixel_out_q;

	// A negative quotient is never also flagged as too large.
	a_div_flags: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.vld |-> !(div_res.neg && div_res.sat))
		else $error("divider reports negative and saturated at once");

	// The exponential never exceeds one in Q30.
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_tag.vld |-> (exp_e <= Q30_ONE))
		else $error("exponential result above one");

endmodule

@@ hw/rtl/vwpm_div.sv @@
module vwpm_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [vwpm_pkg::NUM_W-1:0]  num,
	input  logic        [vwpm_pkg::DEN_W-1:0]  den,
	output vwpm_pkg::vwpm_quo_t                res
);
	import vwpm_pkg::*;

	localparam int STEPS = OUT_W;

	logic             vld_s [0:STEPS];
	logic             neg_s [0:STEPS];
	logic             sat_s [0:STEPS];
	logic [DEN_W-1:0] rem_s [0:STEPS];
	logic [DEN_W-1:0] den_s [0:STEPS];
	logic [OUT_W-1:0] low_s [0:STEPS];
	logic [OUT_W-1:0] quo_s [0:STEPS];

	logic [NUM_W-1:0] num_u;
	logic [NUM_W-1:0] big;
	logic             neg_in;
	logic             sat_in;

	// Classify the numerator: negative, or quotient of 2^16 or more.
	assign num_u  = num;
	assign big    = NUM_W'({den, {OUT_W{1'b0}}});
	assign neg_in = num[NUM_W-1];
	assign sat_in = !neg_in && (num_u >= big);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0] <= neg_in;
		sat_s[0] <= sat_in;
		rem_s[0] <= num_u[OUT_W +: DEN_W];
		low_s[0] <= num_u[OUT_W-1:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar K = 1; K <= STEPS; K++) begin : g_step
		logic [DEN_W:0]   trial;
		logic             ge;
		logic [DEN_W-1:0] rem_nx;

		assign trial  = {rem_s[K-1], low_s[K-1][OUT_W-1]};
		assign ge     = trial >= {1'b0, den_s[K-1]};
		assign rem_nx = ge ? DEN_W'(trial - {1'b0, den_s[K-1]}) : trial[DEN_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[K] <= 1'b0;
			end else begin
				vld_s[K] <= vld_s[K-1];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[K] <= neg_s[K-1];
			sat_s[K] <= sat_s[K-1];
			rem_s[K] <= rem_nx;
			den_s[K] <= den_s[K-1];
			low_s[K] <= {low_s[K-1][OUT_W-2:0], 1'b0};
			quo_s[K] <= {quo_s[K-1][OUT_W-2:0], ge};
		end
	end

	assign res.vld = vld_s[STEPS];
	assign res.neg = neg_s[STEPS];
	assign res.sat = sat_s[STEPS];
	assign res.quo = quo_s[STEPS];

endmodule

@@ hw/rtl/vwpm_exp.sv @@
module vwpm_exp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  vwpm_pkg::vwpm_tag_t            in_tag,
	input  logic [vwpm_pkg::VQ_W-1:0]      v_in,
	output vwpm_pkg::vwpm_tag_t            out_tag,
	output logic [vwpm_pkg::Q_W-1:0]       e_out
);
	import vwpm_pkg::*;

	localparam int PROD_W  = Q_W + VQ_W;
	localparam int RPROD_W = Q_W + RCP_W;
	localparam int SQ_W    = 2 * Q_W;

	// Per term: multiply stage, reciprocal stage, correction stage.
	vwpm_tag_t         a_tag_s  [1:TERMS];
	logic [PROD_W-1:0] a_prod_s [1:TERMS];
	logic [Q_W-1:0]    a_sum_s  [1:TERMS];
	logic [VQ_W-1:0]   a_v_s    [1:TERMS];

	vwpm_tag_t          b_tag_s [1:TERMS];
	logic [Q_W-1:0]     b_x_s   [1:TERMS];
	logic [RPROD_W-1:0] b_y_s   [1:TERMS];
	logic [Q_W-1:0]     b_sum_s [1:TERMS];
	logic [VQ_W-1:0]    b_v_s   [1:TERMS];

	vwpm_tag_t       c_tag_s  [1:TERMS];
	logic [Q_W-1:0]  c_term_s [1:TERMS];
	logic [Q_W-1:0]  c_sum_s  [1:TERMS];
	logic [VQ_W-1:0] c_v_s    [1:TERMS];

	vwpm_tag_t      sq_tag_s [1:SQUARINGS];
	logic [Q_W-1:0] sq_val_s [1:SQUARINGS];

	// Alternating Taylor series of exp(-v), one term per three stages.
	for (genvar I = 1; I <= TERMS; I++) begin : g_term
		localparam logic [RCP_W-1:0] RCP = vwpm_recip(I);
		localparam bit ODD = (I % 2) == 1;

		vwpm_tag_t       tag_in;
		logic [Q_W-1:0]  term_in;
		logic [Q_W-1:0]  sum_in;
		logic [VQ_W-1:0] v_t;
		logic [Q_W-1:0]  x;
		logic [Q_W-1:0]  qp;
		logic [Q_W-1:0]  qi;
		logic [Q_W-1:0]  term_nx;
		logic [Q_W-1:0]  sum_nx;

		if (I == 1) begin : g_first
			assign tag_in  = in_tag;
			assign term_in = Q30_ONE;
			assign sum_in  = Q30_ONE;
			assign v_t     = v_in;
		end else begin : g_chain
			assign tag_in  = c_tag_s[I-1];
			assign term_in = c_term_s[I-1];
			assign sum_in  = c_sum_s[I-1];
			assign v_t     = c_v_s[I-1];
		end

		// Previous term times v, back to Q30.
		assign x = a_prod_s[I][Q_FRAC +: Q_W];

		// Reciprocal estimate is low by at most one; one compare fixes it.
		assign qp      = b_y_s[I][RCP_SH +: Q_W];
		assign qi      = qp * Q_W'(I);
		assign term_nx = ((b_x_s[I] - qi) >= Q_W'(I)) ? qp + Q_W'(1) : qp;
		assign sum_nx  = ODD ? b_sum_s[I] - term_nx : b_sum_s[I] + term_nx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_tag_s[I] <= '0;
				b_tag_s[I] <= '0;
				c_tag_s[I] <= '0;
			end else begin
				a_tag_s[I] <= tag_in;
				b_tag_s[I] <= a_tag_s[I];
				c_tag_s[I] <= b_tag_s[I];
			end
		end

		always_ff @(posedge clk) begin
			a_prod_s[I] <= PROD_W'(term_in) * PROD_W'(v_t);
			a_sum_s[I]  <= sum_in;
			a_v_s[I]    <= v_t;
			b_x_s[I]    <= x;
			b_y_s[I]    <= RPROD_W'(x) * RPROD_W'(RCP);
			b_sum_s[I]  <= a_sum_s[I];
			b_v_s[I]    <= a_v_s[I];
			c_term_s[I] <= term_nx;
			c_sum_s[I]  <= sum_nx;
			c_v_s[I]    <= b_v_s[I];
		end
	end

	// Five squarings raise exp(-v) to exp(-32 v).
	for (genvar K = 1; K <= SQUARINGS; K++) begin : g_square
		vwpm_tag_t      tag_in;
		logic [Q_W-1:0] val_in;
		logic [SQ_W-1:0] prod;

		if (K == 1) begin : g_first
			assign tag_in = c_tag_s[TERMS];
			assign val_in = c_sum_s[TERMS];
		end else begin : g_chain
			assign tag_in = sq_tag_s[K-1];
			assign val_in = sq_val_s[K-1];
		end

		assign prod = SQ_W'(val_in) * SQ_W'(val_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_tag_s[K] <= '0;
			end else begin
				sq_tag_s[K] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			sq_val_s[K] <= prod[Q_FRAC +: Q_W];
		end
	end

	// Far outside the window the exponential is taken as zero.
	assign out_tag = sq_tag_s[SQUARINGS];
	assign e_out   = out_tag.sat ? '0 : sq_val_s[SQUARINGS];

endmodule

@@ test/tb_voi_window_pixel_mapper_unit.sv @@
module tb_voi_window_pixel_mapper_unit;
	import vwpm_pkg::*;

	localparam longint Q_ONE = 64'sd1 << 30;
	localparam int SIG_LAT = 92;
	localparam longint CYCLE_LIMIT = 400000;

	// Mode codes that only the testbench drives.
	localparam logic [1:0] MODE_EXACT = 2'd1;
	localparam logic [1:0] MODE_UNDEF = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [PIXEL_BITS-1:0] pixel_in;
	logic done;
	logic [OUT_W-1:0] pixel_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Register shadow used by the predictor.
	logic [1:0] sh_mode;
	logic signed [15:0] sh_center;
	logic [15:0] sh_width;
	logic [15:0] sh_min;
	logic [15:0] sh_max;

	logic signed [PIXEL_BITS-1:0] pixel_queue[$];
	logic [OUT_W-1:0] expected_pixels[$];
	int error_count;
	longint cycle_count;
	int pixels_sent;
	int pixels_checked;
	bit gaps_enabled;
	int gap_left;

	voi_window_pixel_mapper_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_in(pixel_in), .done(done), .pixel_out(pixel_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	// exp(-32 v) in Q30 by a truncated series and five squarings.
	function automatic longint exp_q30(longint v);
		longint acc;
		longint term;
		acc = Q_ONE;
		term = Q_ONE;
		for (int i = 1; i <= 12; i++) begin
			term = ((term * v) >>> 30) / i;
			if (i % 2 == 1) acc -= term;
			else acc += term;
		end
		for (int k = 0; k < 5; k++) begin
			acc = longint'((longint'(unsigned'(acc)) * acc) >>> 30);
		end
		return acc;
	endfunction

	function automatic logic [OUT_W-1:0] mapped_pixel(logic signed [PIXEL_BITS-1:0] p);
		longint w, lo, hi, span, delta, mag, e, num, den, val;
		w = (sh_width == 0) ? 1 : longint'(sh_width);
		lo = sh_min;
		hi = sh_max;
		span = hi - lo;
		delta = longint'(p) - longint'(sh_center);
		if (sh_mode == MODE_SIGMOID) begin
			mag = (delta < 0) ? -delta : delta;
			if (mag >= 8 * w) e = 0;
			else e = exp_q30((mag << 27) / w);
			num = (delta >= 0) ? Q_ONE : e;
			den = Q_ONE + e;
			// 2*r*n can exceed 64 bits only beyond 17+31+1 bits; it fits.
			val = lo + floor_quot(2 * span * num + den, 2 * den);
		end else begin
			val = lo + floor_quot(span * (2 * delta + w) + w, 2 * w);
		end
		// Lower bound wins when the span is inverted.
		if (val < lo) val = lo;
		else if (val > hi) val = hi;
		return val[OUT_W-1:0];
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	// Driver: one pixel transfer per start with busy low, random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			pixel_in <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_pixels.push_back(mapped_pixel(pixel_in));
				pixels_sent++;
			end
			if (start && busy) begin
				// Hold the current pixel until it is taken.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 3);
			end else if (pixel_queue.size() > 0) begin
				start <= 1'b1;
				pixel_in <= pixel_queue.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each strobed result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (done) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", pixel_out));
				end else begin
					if (pixel_out !== expected_pixels[0])
						report_mismatch($sformatf("pixel_out %0d, wanted %0d (mode %0d)",
							pixel_out, expected_pixels[0], sh_mode));
					void'(expected_pixels.pop_front());
					pixels_checked++;
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// One register write, with cfg_valid dropped again before the task returns.
	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE: sh_mode = value[1:0];
			REG_CENTER: sh_center = value;
			REG_WIDTH: sh_width = value;
			REG_OUT_MIN: sh_min = value;
			REG_OUT_MAX: sh_max = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Waits until the queue has drained and every result has arrived.
	// Sampled on the falling edge, after the driver has settled.
	task automatic drain_all();
		do @(negedge clk);
		while (pixel_queue.size() > 0 || start || expected_pixels.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(logic [1:0] m, logic [15:0] c, logic [15:0] w,
			logic [15:0] lo, logic [15:0] hi);
		drain_all();
		write_reg(REG_MODE, {14'd0, m});
		write_reg(REG_CENTER, c);
		write_reg(REG_WIDTH, w);
		write_reg(REG_OUT_MIN, lo);
		write_reg(REG_OUT_MAX, hi);
	endtask

	// Pixels clustered around the window, with some anywhere in range.
	function automatic logic signed [PIXEL_BITS-1:0] random_pixel();
		longint p;
		if ($urandom_range(0, 3) == 0) return PIXEL_BITS'($urandom);
		p = longint'(sh_center) + longint'($urandom_range(0, 2 * sh_width + 2))
			- longint'(sh_width) - 1;
		if (p > 32767) p = 32767;
		if (p < -32768) p = -32768;
		return p[PIXEL_BITS-1:0];
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		sh_mode = MODE_LINEAR;
		sh_center = CENTER_RST;
		sh_width = WIDTH_RST;
		sh_min = OUT_MIN_RST;
		sh_max = OUT_MAX_RST;
		error_count = 0;
		cycle_count = 0;
		pixels_sent = 0;
		pixels_checked = 0;
		gaps_enabled = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset window, field extremes and window edges.
		pixel_queue = '{-32768, 32767, 0, -1, 40, -160, 240, 239, -161, 1, 16'sh5555};
		drain_all();
		// Sigmoid with the widest span, then the tail, center and saturation.
		set_window(MODE_SIGMOID, 16'sd0, 16'd100, 16'd0, 16'hFFFF);
		pixel_queue = '{0, 1, -1, 100, -100, 799, 800, -799, -800, 32767, -32768};
		drain_all();
		// Narrowest window in linear exact mode, and an inverted span.
		set_window(MODE_EXACT, 16'h8000, 16'd1, 16'd1000, 16'd10);
		pixel_queue = '{-32768, -32767, 0, 32767};
		drain_all();
		// Widest window, full output range, center at its top.
		set_window(MODE_LINEAR, 16'h7FFF, 16'hFFFF, 16'd0, 16'hFFFF);
		pixel_queue = '{-32768, 32767, 0};

		// Random phases, each with fresh window settings.
		for (int ph = 0; ph < 16; ph++) begin
			logic [1:0] m;
			logic [15:0] w;
			m = 2'($urandom_range(0, 2));
			if (ph == 15) m = MODE_UNDEF;
			w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
				: 16'($urandom_range(1, 2000));
			set_window(m, 16'($urandom), w, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			if ($urandom_range(0, 3) != 0 && sh_min > sh_max)
				write_reg(REG_OUT_MAX, 16'($urandom_range(sh_min, 65535)));
			if (ph >= 13) gaps_enabled = 1'b0;
			for (int k = 0; k < 100; k++) pixel_queue.push_back(random_pixel());
		end

		drain_all();
		repeat (SIG_LAT + 10) @(posedge clk);
		$display("Covered %0d pixels, %0d results checked, in linear, sigmoid and",
			pixels_sent, pixels_checked);
		$display("undefined modes with inverted spans and extreme windows.");
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
